// ----- hw/rtl/m4vt_pkg.sv -----
// m4vt_pkg: types, constants and single-precision arithmetic steps for the
// 4x4 matrix-vector transform core. Used by mat4_vec4_transform_core.
`default_nettype none

package m4vt_pkg;

	localparam int NumRows   = 4;
	localparam int NumCols   = 4;
	localparam int NumPairs  = 8;
	localparam int PairIdxW  = $clog2(NumPairs);
	localparam int CfgDataW  = 64;
	localparam int FpW       = 32;
	localparam int VecW      = NumRows * FpW;
	localparam int NumStages = 12;
	localparam int NumAdds   = NumCols - 1;

	localparam logic [FpW-1:0] CanonNan = 32'h7FC0_0000;

	typedef logic [FpW-1:0] fp32_t;

	// product before normalization
	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic               zero;
		logic signed [11:0] e;
		logic [47:0]        man;
	} fmul_a_t;

	// normalized value, leading one at bit 26, sticky in bit 0
	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic               zero;
		logic signed [11:0] e;
		logic [26:0]        m;
	} fnorm_t;

	// aligned operands
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        sub;
		logic [7:0]  e;
		logic [26:0] big;
		logic [26:0] small_m;
	} fadd_a_t;

	// raw sum with leading zero count
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        sub;
		logic [7:0]  e;
		logic [27:0] sum;
		logic [4:0]  lz;
	} fadd_b_t;

	function automatic fmul_a_t fmul_a(fp32_t a, fp32_t b);
		fmul_a_t    r;
		logic [7:0] ea, eb, ea_eff, eb_eff;
		logic       na, nb, ia, ib, za, zb;
		logic [23:0] ma, mb;
		ea = a[30:23];
		eb = b[30:23];
		na = (ea == 8'hFF) && (a[22:0] != 23'd0);
		nb = (eb == 8'hFF) && (b[22:0] != 23'd0);
		ia = (ea == 8'hFF) && (a[22:0] == 23'd0);
		ib = (eb == 8'hFF) && (b[22:0] == 23'd0);
		za = (ea == 8'd0) && (a[22:0] == 23'd0);
		zb = (eb == 8'd0) && (b[22:0] == 23'd0);
		ea_eff = (ea == 8'd0) ? 8'd1 : ea;
		eb_eff = (eb == 8'd0) ? 8'd1 : eb;
		ma = {ea != 8'd0, a[22:0]};
		mb = {eb != 8'd0, b[22:0]};
		r.sign = a[31] ^ b[31];
		r.nan  = na | nb | (ia & zb) | (za & ib);
		r.inf  = ia | ib;
		r.zero = za | zb;
		r.e    = $signed({4'd0, ea_eff}) + $signed({4'd0, eb_eff}) - 12'sd127;
		r.man  = ma * mb;
		return r;
	endfunction

	function automatic fnorm_t fmul_b(fmul_a_t a);
		fnorm_t      r;
		logic [5:0]  lz;
		logic [47:0] sh;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (a.man[i]) begin
				lz = 6'(47 - i);
			end
		end
		sh = a.man << lz;
		r.sign = a.sign;
		r.nan  = a.nan;
		r.inf  = a.inf;
		r.zero = a.zero;
		r.e    = a.e - $signed({6'd0, lz}) + 12'sd1;
		r.m    = {sh[47:22], |sh[21:0]};
		return r;
	endfunction

	function automatic fp32_t fp_round(fnorm_t n);
		logic [4:0]  rs;
		logic [11:0] tmp;
		logic [26:0] m2, lost_mask;
		logic [7:0]  ef;
		logic [30:0] mag;
		logic        inc;
		fp32_t       res;
		tmp = 12'sd1 - n.e;
		if (n.e >= 12'sd1) begin
			rs = 5'd0;
		end else if (n.e <= -12'sd26) begin
			rs = 5'd27;
		end else begin
			rs = tmp[4:0];
		end
		lost_mask = ~(27'h7FF_FFFF << rs);
		m2 = n.m >> rs;
		m2[0] = m2[0] | (|(n.m & lost_mask));
		ef = (n.e >= 12'sd1) ? n.e[7:0] : 8'd0;
		inc = m2[2] & (m2[1] | m2[0] | m2[3]);
		mag = {ef, m2[25:3]} + 31'(inc);
		if (n.nan) begin
			res = CanonNan;
		end else if (n.inf || (n.e >= 12'sd255)) begin
			res = {n.sign, 8'hFF, 23'd0};
		end else if (n.zero) begin
			res = {n.sign, 31'd0};
		end else begin
			res = {n.sign, mag};
		end
		return res;
	endfunction

	function automatic fadd_a_t fadd_a(fp32_t a, fp32_t b);
		fadd_a_t     r;
		logic        na, nb, ia, ib, swp;
		fp32_t       x, y;
		logic [7:0]  ex_eff, ey_eff, d;
		logic [4:0]  sh;
		logic [26:0] sm_full;
		na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		swp = b[30:0] > a[30:0];
		x = swp ? b : a;
		y = swp ? a : b;
		ex_eff = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey_eff = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d = ex_eff - ey_eff;
		sh = (d > 8'd27) ? 5'd27 : d[4:0];
		sm_full = {y[30:23] != 8'd0, y[22:0], 3'b000};
		r.nan = na | nb | (ia & ib & (a[31] != b[31]));
		r.inf = ia | ib;
		r.sign = (ia | ib) ? (ia ? a[31] : b[31]) : x[31];
		r.sub = x[31] ^ y[31];
		r.e = ex_eff;
		r.big = {x[30:23] != 8'd0, x[22:0], 3'b000};
		r.small_m = sm_full >> sh;
		r.small_m[0] = r.small_m[0] | (|(sm_full & ~(27'h7FF_FFFF << sh)));
		return r;
	endfunction

	function automatic fadd_b_t fadd_b(fadd_a_t a);
		fadd_b_t r;
		r.sign = a.sign;
		r.nan  = a.nan;
		r.inf  = a.inf;
		r.sub  = a.sub;
		r.e    = a.e;
		r.sum  = a.sub ? ({1'b0, a.big} - {1'b0, a.small_m})
		               : ({1'b0, a.big} + {1'b0, a.small_m});
		r.lz   = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (r.sum[i]) begin
				r.lz = 5'(26 - i);
			end
		end
		return r;
	endfunction

	function automatic fnorm_t fadd_norm(fadd_b_t b);
		fnorm_t      r;
		logic        zero;
		logic [26:0] shl;
		zero = (b.sum == 28'd0) && !b.nan && !b.inf;
		shl = b.sum[26:0] << b.lz;
		r.nan  = b.nan;
		r.inf  = b.inf;
		r.zero = zero;
		r.sign = zero ? (b.sub ? 1'b0 : b.sign) : b.sign;
		if (b.sum[27]) begin
			r.m = {b.sum[27:2], |b.sum[1:0]};
			r.e = $signed({4'd0, b.e}) + 12'sd1;
		end else begin
			r.m = shl;
			r.e = $signed({4'd0, b.e}) - $signed({7'd0, b.lz});
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mat4_vec4_transform_core.sv -----
// mat4_vec4_transform_core: 4x4 single-precision matrix times 4-vector.
// Depends on m4vt_pkg for the types and the float arithmetic steps.
//
// The matrix sits in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_data, column-major, two elements per register (lower
// element in bits 31..0). Write them only while no item is in flight.
// Vectors come in on the s_ group (x, y, z, w from the low bits up), one
// result vector per item goes out on the m_ group in the same packing.
// Each row is the sum over columns j of m[j][row]*v[j], products rounded
// first, then added in column order onto +0, round to nearest even.
// Pipeline: three stages of multiply (product, normalize, round) and three
// stages per addition (align, add, normalize and round), twelve in all.
// One item per cycle is taken while the output side keeps up.
// When m_tready is low, the last stage holds its item and stages behind it
// close up their bubbles before s_tready drops; nothing is lost.
// Reset clears the matrix to zeros and empties the pipeline.
`default_nettype none

module mat4_vec4_transform_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [m4vt_pkg::PairIdxW-1:0]   cfg_index,
	input  logic [m4vt_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [m4vt_pkg::VecW-1:0]       s_tdata,  // in_x, in_y, in_z, in_w
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [m4vt_pkg::VecW-1:0]       m_tdata   // out_x, out_y, out_z, out_w
);

	localparam int R  = m4vt_pkg::NumRows;
	localparam int C  = m4vt_pkg::NumCols;
	localparam int NS = m4vt_pkg::NumStages;
	localparam int NA = m4vt_pkg::NumAdds;

	logic [m4vt_pkg::CfgDataW-1:0] mat_q [m4vt_pkg::NumPairs];
	logic [NS-1:0]                 v_q;
	logic [NS-1:0]                 en;

	m4vt_pkg::fmul_a_t mul_s1  [C][R];
	m4vt_pkg::fnorm_t  mul_s2  [C][R];
	m4vt_pkg::fp32_t   prod_s3 [C][R];
	m4vt_pkg::fp32_t   acc_s3  [R];

	m4vt_pkg::fadd_a_t add_a_s [NA][R];
	m4vt_pkg::fadd_b_t add_b_s [NA][R];
	m4vt_pkg::fp32_t   acc_c_s [NA][R];
	m4vt_pkg::fp32_t   pr_a_s  [NA][C][R];
	m4vt_pkg::fp32_t   pr_b_s  [NA][C][R];
	m4vt_pkg::fp32_t   pr_c_s  [NA-1][C][R];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < m4vt_pkg::NumPairs; i++) begin
				mat_q[i] <= '0;
			end
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// stage advances when empty or when the next one advances
	always_comb begin
		en[NS-1] = !v_q[NS-1] || m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NS-1];

	for (genvar c = 0; c < C; c++) begin : g_col
		for (genvar r = 0; r < R; r++) begin : g_row
			localparam int Idx = c * R + r;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					mul_s1[c][r] <= m4vt_pkg::fmul_a(
						mat_q[Idx / 2][(Idx % 2) * 32 +: 32], s_tdata[c*32 +: 32]);
				end
				if (en[1]) begin
					mul_s2[c][r] <= m4vt_pkg::fmul_b(mul_s1[c][r]);
				end
				if (en[2]) begin
					prod_s3[c][r] <= m4vt_pkg::fp_round(mul_s2[c][r]);
				end
			end
		end
	end

	// +0 plus the first product: only a negative zero changes
	for (genvar r = 0; r < R; r++) begin : g_acc0
		always_ff @(posedge clk) begin
			if (en[2]) begin
				acc_s3[r] <= (m4vt_pkg::fp_round(mul_s2[0][r]) == 32'h8000_0000) ? '0 :
				             m4vt_pkg::fp_round(mul_s2[0][r]);
			end
		end
	end

	for (genvar k = 0; k < NA; k++) begin : g_add
		for (genvar r = 0; r < R; r++) begin : g_row
			m4vt_pkg::fp32_t acc_in;
			m4vt_pkg::fp32_t pr_in [C];
			if (k == 0) begin : g_first
				assign acc_in = acc_s3[r];
				for (genvar c = 0; c < C; c++) begin : g_p
					assign pr_in[c] = prod_s3[c][r];
				end
			end else begin : g_next
				assign acc_in = acc_c_s[k-1][r];
				for (genvar c = 0; c < C; c++) begin : g_p
					assign pr_in[c] = pr_c_s[k-1][c][r];
				end
			end
			always_ff @(posedge clk) begin
				if (en[3 + 3*k]) begin
					add_a_s[k][r] <= m4vt_pkg::fadd_a(acc_in, pr_in[k+1]);
					for (int c = 0; c < C; c++) begin
						pr_a_s[k][c][r] <= pr_in[c];
					end
				end
				if (en[4 + 3*k]) begin
					add_b_s[k][r] <= m4vt_pkg::fadd_b(add_a_s[k][r]);
					for (int c = 0; c < C; c++) begin
						pr_b_s[k][c][r] <= pr_a_s[k][c][r];
					end
				end
				if (en[5 + 3*k]) begin
					acc_c_s[k][r] <= m4vt_pkg::fp_round(m4vt_pkg::fadd_norm(add_b_s[k][r]));
				end
			end
			if (k < NA - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en[5 + 3*k]) begin
						for (int c = 0; c < C; c++) begin
							pr_c_s[k][c][r] <= pr_b_s[k][c][r];
						end
					end
				end
			end
		end
	end

	for (genvar r = 0; r < R; r++) begin : g_out
		assign m_tdata[r*32 +: 32] = acc_c_s[NA-1][r];
	end

`ifndef SYNTHESIS
	a_empty_head_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[0] |-> s_tready)
		else $error("input stalled with empty first stage");

	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[5] && !en[6] |=> v_q[5])
		else $error("stalled item dropped in the pipeline");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost or changed");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0)
		|-> m_tdata[31:0] == m4vt_pkg::CanonNan)
		else $error("non-canonical nan on out_x");
`endif

endmodule

`default_nettype wire
